// ===== src/pob_pkg.sv =====
`default_nettype none
package pob_pkg;

   localparam int unsigned BUF_DEPTH = 16;
   localparam int unsigned COUNT_W   = $clog2(BUF_DEPTH + 1);

   localparam int unsigned KIND_W   = 2;
   localparam int unsigned VALUE_W  = 8;
   localparam int unsigned PRIO_W   = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned OCC_W    = 5;

   localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXCHANGE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]  prio;
   } entry_type;

   localparam entry_type EMPTY_ENTRY = '{valid: 1'b0, value: '0, prio: '0};

   // Broadcast to every cell in the chain
   typedef struct packed {
      logic      shift;   // front entry leaves, all move one place forward
      logic      insert;  // new entry drops into its place
      entry_type fresh;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ===== src/pob_if.sv =====
`default_nettype none
interface pob_req_if;
   logic                           valid;
   logic                           ready;
   logic [pob_pkg::KIND_W-1:0]     kind;
   logic [pob_pkg::VALUE_W-1:0]    item_value;
   logic [pob_pkg::PRIO_W-1:0]     item_priority;

   modport source (output valid, output kind, output item_value, output item_priority,
                   input ready);
   modport sink   (input valid, input kind, input item_value, input item_priority,
                   output ready);
endinterface

interface pob_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           out_valid;
   logic [pob_pkg::VALUE_W-1:0]    out_value;
   logic [pob_pkg::PRIO_W-1:0]     out_priority;
   logic [pob_pkg::STATUS_W-1:0]   status;
   logic [pob_pkg::OCC_W-1:0]      occupancy;

   modport source (output valid, output out_valid, output out_value, output out_priority,
                   output status, output occupancy, input ready);
   modport sink   (input valid, input out_valid, input out_value, input out_priority,
                   input status, input occupancy, output ready);
endinterface
`default_nettype wire

// ===== src/priority_ordered_buffer_unit.sv =====
`default_nettype none
// Channel | Dir | Beat contents
// req     | in  | kind, item_value, item_priority
// rsp     | out | out_valid, out_value, out_priority, status, occupancy
//
// One request beat per cycle; its response beat is registered and shows the next cycle.
// The whole update (remove, insert or both) happens in one pass through the cell chain:
// every cell compares its priority with the new entry and picks its own, its neighbour's
// or the new entry. Reset empties all cells at once. A stalled response holds the
// request side only while the response register is full and not being taken.
module priority_ordered_buffer_unit (
   input  logic      clock,
   input  logic      reset,
   pob_req_if.sink   req_bus,
   pob_rsp_if.source rsp_bus
);
   import pob_pkg::*;

   logic                  fire;
   logic                  rem_req, ins_req, rem_ok, ins_ok;
   logic [COUNT_W-1:0]    count_ff, count_in;
   cell_ctrl_type         ctrl;
   entry_type             cell_q    [BUF_DEPTH];
   logic                  cell_keeps[BUF_DEPTH];

   logic                  rsp_valid_ff;
   logic                  out_valid_ff;
   logic [VALUE_W-1:0]    out_value_ff;
   logic [PRIO_W-1:0]     out_priority_ff;
   logic [STATUS_W-1:0]   status_ff;
   logic [STATUS_W-1:0]   status_in;

   // Response register frees up when its beat is taken
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign fire          = req_bus.valid && req_bus.ready;

   assign rem_req = (req_bus.kind == KIND_REMOVE) || (req_bus.kind == KIND_EXCHANGE);
   assign ins_req = (req_bus.kind == KIND_INSERT) || (req_bus.kind == KIND_EXCHANGE);
   assign rem_ok  = rem_req && (count_ff != '0);
   // exchange on a full buffer frees its own slot first
   assign ins_ok  = ins_req && ((count_ff != COUNT_W'(BUF_DEPTH)) || rem_ok);

   assign ctrl.shift       = fire && rem_ok;
   assign ctrl.insert      = fire && ins_ok;
   assign ctrl.fresh.valid = 1'b1;
   assign ctrl.fresh.value = req_bus.item_value;
   assign ctrl.fresh.prio  = req_bus.item_priority;

   always_comb begin
      priority if (ins_req && !ins_ok) begin
         status_in = STATUS_FULL;
      end else if (rem_req && !rem_ok) begin
         status_in = STATUS_EMPTY;
      end else begin
         status_in = STATUS_OK;
      end
   end

   assign count_in = count_ff - COUNT_W'(rem_ok) + COUNT_W'(ins_ok);

   // Cell 0 is the front; the last cell pulls in an empty slot on a shift.
   for (genvar i = 0; i < BUF_DEPTH; i++) begin : g_cell
      entry_type left_q, right_q;
      logic      left_keeps;

      if (i == 0) begin : g_front
         assign left_q     = EMPTY_ENTRY;
         assign left_keeps = 1'b1;
      end else begin : g_inner
         assign left_q     = cell_q[i-1];
         assign left_keeps = cell_keeps[i-1];
      end

      if (i == BUF_DEPTH - 1) begin : g_back
         assign right_q = EMPTY_ENTRY;
      end else begin : g_mid
         assign right_q = cell_q[i+1];
      end

      pob_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left_q     (left_q),
         .right_q    (right_q),
         .left_keeps (left_keeps),
         .keeps      (cell_keeps[i]),
         .q          (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            count_ff <= count_in;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload only, no reset
   always_ff @(posedge clock) begin
      if (fire) begin
         out_valid_ff    <= rem_ok;
         out_value_ff    <= rem_ok ? cell_q[0].value : '0;
         out_priority_ff <= rem_ok ? cell_q[0].prio  : '0;
         status_ff       <= status_in;
      end
   end

   logic [OCC_W-1:0] occ_ff;
   always_ff @(posedge clock) begin
      if (fire) begin
         occ_ff <= OCC_W'(count_in);
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_valid    = out_valid_ff;
   assign rsp_bus.out_value    = out_value_ff;
   assign rsp_bus.out_priority = out_priority_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.occupancy    = occ_ff;

endmodule
`default_nettype wire

// ===== src/pob_cell.sv =====
`default_nettype none
module pob_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  pob_pkg::cell_ctrl_type ctrl,
   input  pob_pkg::entry_type     left_q,    // neighbour nearer the front
   input  pob_pkg::entry_type     right_q,   // neighbour nearer the back
   input  logic                   left_keeps,
   output logic                   keeps,
   output pob_pkg::entry_type     q
);
   import pob_pkg::*;

   entry_type entry_ff, entry_in;
   entry_type base, below;

   // After an optional forward shift, base is what sits here, below what sits in front.
   assign base  = ctrl.shift ? right_q  : entry_ff;
   assign below = ctrl.shift ? entry_ff : left_q;

   // Stays put on insert: served no later than the new entry
   assign keeps = base.valid && (base.prio <= ctrl.fresh.prio);

   always_comb begin
      priority if (!ctrl.insert || keeps) begin
         entry_in = base;
      end else if (left_keeps) begin
         entry_in = ctrl.fresh;
      end else begin
         entry_in = below;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= EMPTY_ENTRY;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign q = entry_ff;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pob_pkg::*;

   // Request kind 3 is not a defined operation: the block answers with no entry and status OK
   localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

   // Modes used to steer the random traffic towards full or empty
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_type;

   // What one response beat should carry
   typedef struct {
      logic                out_valid;
      logic [VALUE_W-1:0]  value;
      logic [PRIO_W-1:0]   prio;
      logic [STATUS_W-1:0] status;
      logic [OCC_W-1:0]    occupancy;
   } outcome_type;

   logic clock;
   logic reset;

   pob_req_if req_if();
   pob_rsp_if rsp_if();

   priority_ordered_buffer_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if.sink),
      .rsp_bus (rsp_if.source)
   );

   // Shadow copy of the buffer, kept in serve order (front at index 0)
   logic [VALUE_W-1:0] shadow_value [BUF_DEPTH];
   logic [PRIO_W-1:0]  shadow_prio  [BUF_DEPTH];
   int unsigned        shadow_count;

   // Outcomes of accepted requests whose response beat has not been seen yet
   outcome_type predicted_outcomes [$];

   int error_count   = 0;
   int send_idle_pct = 0;   // chance per cycle that the sender holds back
   int rsp_stall_pct = 0;   // chance per cycle that the receiver drops ready

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs; far beyond the slowest legal run
   initial begin
      #500_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver: ready toggles at random according to the current stall rate
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Apply one request to the shadow buffer and work out its response.
   // Remove happens first, so an exchange on a full buffer still inserts,
   // and an exchange on an empty one fails the remove but stores the entry.
   function automatic outcome_type apply_request(logic [KIND_W-1:0]  kind,
                                                 logic [VALUE_W-1:0] val,
                                                 logic [PRIO_W-1:0]  pri);
      outcome_type o;
      int unsigned pos;
      o = '{default: '0};
      if (kind == KIND_REMOVE || kind == KIND_EXCHANGE) begin
         if (shadow_count == 0) begin
            o.status = STATUS_EMPTY;
         end else begin
            o.out_valid = 1'b1;
            o.value     = shadow_value[0];
            o.prio      = shadow_prio[0];
            for (int unsigned i = 1; i < shadow_count; i++) begin
               shadow_value[i-1] = shadow_value[i];
               shadow_prio[i-1]  = shadow_prio[i];
            end
            shadow_count--;
            shadow_value[shadow_count] = '0;
            shadow_prio[shadow_count]  = '0;
         end
      end
      if (kind == KIND_INSERT || kind == KIND_EXCHANGE) begin
         if (shadow_count >= BUF_DEPTH) begin
            o.status = STATUS_FULL;
         end else begin
            // new entry goes behind every entry of equal or better priority
            pos = 0;
            while (pos < shadow_count && shadow_prio[pos] <= pri) pos++;
            for (int unsigned i = shadow_count; i > pos; i--) begin
               shadow_value[i] = shadow_value[i-1];
               shadow_prio[i]  = shadow_prio[i-1];
            end
            shadow_value[pos] = val;
            shadow_prio[pos]  = pri;
            shadow_count++;
         end
      end
      o.occupancy = shadow_count[OCC_W-1:0];
      return o;
   endfunction

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Response checker: every accepted beat against the oldest prediction
   always @(posedge clock) begin : check_rsp
      outcome_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (predicted_outcomes.size() == 0) begin
            $error("response beat with no request outstanding");
            error_count++;
         end else begin
            want = predicted_outcomes.pop_front();
            compare_field("out_valid",    want.out_valid, rsp_if.out_valid);
            compare_field("out_value",    want.value,     rsp_if.out_value);
            compare_field("out_priority", want.prio,      rsp_if.out_priority);
            compare_field("status",       want.status,    rsp_if.status);
            compare_field("occupancy",    want.occupancy, rsp_if.occupancy);
         end
      end
   end

   // Send one request beat. Optional idle cycles first (valid low, junk on
   // the payload), then hold the beat until ready. Valid is left high on
   // acceptance so back-to-back beats never see a low-high pair in one step.
   task automatic send_request(logic [KIND_W-1:0]  kind,
                               logic [VALUE_W-1:0] val,
                               logic [PRIO_W-1:0]  pri);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid         <= 1'b0;
         req_if.kind          <= KIND_W'($urandom);
         req_if.item_value    <= VALUE_W'($urandom);
         req_if.item_priority <= PRIO_W'($urandom);
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.kind          <= kind;
      req_if.item_value    <= val;
      req_if.item_priority <= pri;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted_outcomes.push_back(apply_request(kind, val, pri));
   endtask

   // Stop sending and wait until every outstanding response has been taken
   task automatic drain_responses();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (predicted_outcomes.size() != 0) @(posedge clock);
   endtask

   // Directed: empty-buffer corners, no-op, fill to full with every priority
   // and repeated priorities (oldest first among equals), full-buffer corners.
   task automatic test_directed();
      logic [PRIO_W-1:0] fill_prio [15] = '{3, 1, 0, 2, 1, 3, 0, 1, 2, 2, 0, 3, 1, 0, 2};
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_request(KIND_REMOVE,   8'd0,   2'd0);   // remove on empty
      send_request(KIND_NOP,      8'hA5,  2'd3);   // undefined kind
      send_request(KIND_EXCHANGE, 8'd255, 2'd3);   // exchange on empty: insert only
      for (int i = 0; i < 15; i++) begin
         send_request(KIND_INSERT, (i == 0) ? 8'd0 : (i == 14) ? 8'd255 : 8'(i * 17),
                      fill_prio[i]);
      end
      send_request(KIND_INSERT,   8'd77,  2'd0);   // full: rejected
      send_request(KIND_EXCHANGE, 8'd200, 2'd0);   // full: remove frees a slot
      send_request(KIND_NOP,      8'd0,   2'd0);   // no-op while full
      repeat (3) send_request(KIND_REMOVE, 8'hFF, 2'd3);
      drain_responses();
   endtask

   // Random traffic in bursts that lean towards filling, draining or neither,
   // so the buffer keeps visiting both full and empty.
   task automatic test_random(int n_items, int idle_pct, int stall_pct);
      traffic_mix_type mix;
      int roll;
      logic [KIND_W-1:0] kind;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      mix = MIX_BALANCED;
      for (int n = 0; n < n_items; n++) begin
         if (n % 16 == 0) mix = traffic_mix_type'($urandom_range(2));
         roll = $urandom_range(99);
         if (roll < 5) begin
            kind = KIND_NOP;
         end else begin
            case (mix)
               MIX_FILL: begin
                  kind = (roll < 75) ? KIND_INSERT : (roll < 88) ? KIND_EXCHANGE : KIND_REMOVE;
               end
               MIX_DRAIN: begin
                  kind = (roll < 75) ? KIND_REMOVE : (roll < 88) ? KIND_EXCHANGE : KIND_INSERT;
               end
               default: begin
                  kind = (roll < 40) ? KIND_INSERT : (roll < 75) ? KIND_REMOVE : KIND_EXCHANGE;
               end
            endcase
         end
         send_request(kind, VALUE_W'($urandom), PRIO_W'($urandom));
      end
      // sender pauses until the block has answered everything
      drain_responses();
   endtask

   initial begin
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.kind          <= KIND_INSERT;
      req_if.item_value    <= '0;
      req_if.item_priority <= '0;
      shadow_count = 0;
      for (int i = 0; i < BUF_DEPTH; i++) begin
         shadow_value[i] = '0;
         shadow_prio[i]  = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(185,  0,  0);   // no idling
      test_random(185, 52,  0);   // sender idle
      test_random(185,  0, 52);   // receiver stalling
      test_random(185, 15, 15);   // both

      // response is registered behind its request; allow a little slack
      while (predicted_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0 && predicted_outcomes.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
src/pob_pkg.sv
src/pob_if.sv
src/pob_cell.sv
src/priority_ordered_buffer_unit.sv
tb/testbench.sv
